### src/wpp_pkg.sv
`default_nettype none

package wpp_pkg;

    localparam int HEADER_BYTES = 44;

    // Header byte positions that carry the fields the parser keeps
    localparam logic [5:0] POS_CHAN_LO  = 6'd22;
    localparam logic [5:0] POS_CHAN_HI  = 6'd23;
    localparam logic [5:0] POS_ALIGN_LO = 6'd32;
    localparam logic [5:0] POS_ALIGN_HI = 6'd33;
    localparam logic [5:0] POS_BITS_LO  = 6'd34;
    localparam logic [5:0] POS_BITS_HI  = 6'd35;
    localparam logic [5:0] POS_SIZE_B0  = 6'd40;
    localparam logic [5:0] POS_SIZE_B1  = 6'd41;
    localparam logic [5:0] POS_SIZE_B2  = 6'd42;
    localparam logic [5:0] POS_SIZE_B3  = 6'd43;
    localparam logic [5:0] POS_HDR_LAST = 6'(HEADER_BYTES - 1);

    localparam logic [15:0] BITS_8  = 16'd8;
    localparam logic [15:0] BITS_16 = 16'd16;

    localparam int DIV_STEPS = 32;

    typedef enum logic [3:0] {
        ST_HEADER = 4'b0001,
        ST_DIV    = 4'b0010,
        ST_DATA   = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    typedef struct packed {
        logic clear;        // start mark seen: restart header
        logic hdr_step;     // take a header byte
        logic hdr_err;      // block align zero: send error beat
        logic div_start;    // launch frame count divide
        logic frames_load;  // take divide quotient as frame count
        logic data_step;    // take a data byte
    } cmd_t;

    typedef struct packed {
        logic hdr_last;     // current header byte is the last one
        logic fb_zero;      // block align is zero
        logic div_done;     // quotient ready
        logic quot_zero;    // frame count is zero
        logic data_fin;     // current data byte closes the final frame
        logic out_free;     // output register can take a beat
    } status_t;

endpackage

`default_nettype wire

### src/wpp_div.sv
`default_nettype none

module wpp_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             done,
    output logic [31:0]      quot
);
    import wpp_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [15:0] rem_reg, rem_next;
    logic [31:0] quot_reg, quot_next;
    logic [15:0] dsr_reg, dsr_next;
    logic [16:0] shifted;
    logic [16:0] diff;

    // Restoring divide, one quotient bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dsr_next  = dsr_reg;
        shifted   = {rem_reg, quot_reg[31]};
        diff      = shifted - {1'b0, dsr_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quot_next = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[16])
            begin
                rem_next  = diff[15:0];
                quot_next = {quot_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[15:0];
                quot_next = {quot_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dsr_reg  <= dsr_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

### src/wpp_dpath.sv
`default_nettype none

module wpp_dpath (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire wpp_pkg::cmd_t    cmd,
    output wpp_pkg::status_t      status,
    input  wire logic [7:0]       data_byte,
    input  wire logic             out_ready,
    output logic                  out_valid,
    output logic [15:0]           out_value,
    output logic                  out_last,
    output logic                  out_err
);
    import wpp_pkg::*;

    function automatic logic [15:0] pcm_convert(input logic [15:0] raw,
                                                input logic [15:0] bits);
        logic [7:0]  t;
        logic [16:0] ext;
        logic [16:0] p;
        logic [15:0] r;
        t   = raw[7:0] ^ 8'h80;
        ext = {{9{t[7]}}, t};
        p   = (ext << 8) + (ext << 1);
        if (bits == BITS_8)
            r = (p[16] && !p[15]) ? 16'h8000 : p[15:0];
        else if (bits == BITS_16)
            r = raw;
        else
            r = '0;
        return r;
    endfunction

    logic [5:0]  offset_reg, offset_next;
    logic [15:0] chan_total_reg, frame_bytes_reg, sample_bits_reg;
    logic [31:0] data_length_reg;
    logic [31:0] frames_left_reg, frames_left_next;
    logic [12:0] byte_idx_reg, byte_idx_next;
    logic [15:0] chan_idx_reg, chan_idx_next;
    logic [15:0] accum_reg, accum_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_value_reg;
    logic        out_last_reg, out_err_reg;

    logic [5:0]  eff_offset;
    logic [12:0] size;
    logic        size_zero;
    logic [15:0] chans_m1;
    logic        byte_end, chan_first, chan_end, frame_end, frames_one;
    logic [15:0] accum_new;
    logic        data_emit;
    logic [15:0] data_value;
    logic        load_out;
    logic        div_done;
    logic [31:0] quot;

    wpp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({data_byte, data_length_reg[23:0]}),
        .divisor  (frame_bytes_reg),
        .done     (div_done),
        .quot     (quot)
    );

    always_comb
    begin
        eff_offset = cmd.clear ? '0 : offset_reg;
        size       = sample_bits_reg[15:3];
        size_zero  = (size == '0);
        chans_m1   = (chan_total_reg == '0) ? '0 : chan_total_reg - 16'd1;
        byte_end   = (byte_idx_reg == size - 13'd1);
        chan_first = (chan_idx_reg == '0);
        chan_end   = (chan_idx_reg == chans_m1);
        frames_one = (frames_left_reg == 32'd1);
        frame_end  = size_zero || (byte_end && chan_end);

        accum_new = accum_reg;
        if (chan_first)
        begin
            if (byte_idx_reg == 13'd0)
                accum_new[7:0] = data_byte;
            else if (byte_idx_reg == 13'd1)
                accum_new[15:8] = data_byte;
        end
        data_emit  = size_zero || (byte_end && chan_first);
        data_value = size_zero ? '0 : pcm_convert(accum_new, sample_bits_reg);

        status.hdr_last  = (offset_reg == POS_HDR_LAST);
        status.fb_zero   = (frame_bytes_reg == '0);
        status.div_done  = div_done;
        status.quot_zero = (quot == '0);
        status.data_fin  = frame_end && frames_one;
        status.out_free  = !out_valid_reg || out_ready;
    end

    // Sequencing of counters and the output register
    always_comb
    begin
        offset_next      = offset_reg;
        frames_left_next = frames_left_reg;
        byte_idx_next    = byte_idx_reg;
        chan_idx_next    = chan_idx_reg;
        accum_next       = accum_reg;
        load_out         = cmd.hdr_err || (cmd.data_step && data_emit);
        out_valid_next   = out_valid_reg && !out_ready;
        if (load_out)
            out_valid_next = 1'b1;

        if (cmd.hdr_step)
        begin
            if (eff_offset == POS_HDR_LAST)
            begin
                offset_next   = '0;
                byte_idx_next = '0;
                chan_idx_next = '0;
                accum_next    = '0;
            end
            else
                offset_next = eff_offset + 6'd1;
        end

        if (cmd.frames_load)
            frames_left_next = quot;

        if (cmd.data_step)
        begin
            if (size_zero)
                frames_left_next = frames_left_reg - 32'd1;
            else
            begin
                accum_next = accum_new;
                if (byte_end)
                begin
                    byte_idx_next = '0;
                    if (chan_end)
                    begin
                        chan_idx_next    = '0;
                        accum_next       = '0;
                        frames_left_next = frames_left_reg - 32'd1;
                    end
                    else
                        chan_idx_next = chan_idx_reg + 16'd1;
                end
                else
                    byte_idx_next = byte_idx_reg + 13'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg      <= '0;
            frames_left_reg <= '0;
            byte_idx_reg    <= '0;
            chan_idx_reg    <= '0;
            accum_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            offset_reg      <= offset_next;
            frames_left_reg <= frames_left_next;
            byte_idx_reg    <= byte_idx_next;
            chan_idx_reg    <= chan_idx_next;
            accum_reg       <= accum_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Header fields and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.hdr_step)
        begin
            unique case (eff_offset)
                POS_CHAN_LO:  chan_total_reg[7:0]     <= data_byte;
                POS_CHAN_HI:  chan_total_reg[15:8]    <= data_byte;
                POS_ALIGN_LO: frame_bytes_reg[7:0]    <= data_byte;
                POS_ALIGN_HI: frame_bytes_reg[15:8]   <= data_byte;
                POS_BITS_LO:  sample_bits_reg[7:0]    <= data_byte;
                POS_BITS_HI:  sample_bits_reg[15:8]   <= data_byte;
                POS_SIZE_B0:  data_length_reg[7:0]    <= data_byte;
                POS_SIZE_B1:  data_length_reg[15:8]   <= data_byte;
                POS_SIZE_B2:  data_length_reg[23:16]  <= data_byte;
                POS_SIZE_B3:  data_length_reg[31:24]  <= data_byte;
                default: ;
            endcase
        end
        if (load_out)
        begin
            out_value_reg <= cmd.hdr_err ? '0 : data_value;
            out_last_reg  <= cmd.hdr_err ? 1'b0 : frames_one;
            out_err_reg   <= cmd.hdr_err;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;
    assign out_err   = out_err_reg;

endmodule

`default_nettype wire

### src/wpp_ctrl.sv
`default_nettype none

module wpp_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_start,
    output logic                  in_ready,
    input  wire wpp_pkg::status_t status,
    output wpp_pkg::cmd_t         cmd
);
    import wpp_pkg::*;

    state_t state_reg, state_next;
    state_t eff_state;
    logic   accept;

    always_comb
    begin
        in_ready   = (state_reg != ST_DIV) && status.out_free;
        accept     = in_valid && in_ready;
        eff_state  = in_start ? ST_HEADER : state_reg;
        state_next = state_reg;
        cmd        = '0;
        cmd.clear  = accept && in_start;

        if (accept)
        begin
            unique case (eff_state)
                ST_HEADER:
                begin
                    cmd.hdr_step = 1'b1;
                    state_next   = ST_HEADER;
                    if (status.hdr_last && !in_start)
                    begin
                        if (status.fb_zero)
                        begin
                            cmd.hdr_err = 1'b1;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = ST_DIV;
                        end
                    end
                end
                ST_DATA:
                begin
                    cmd.data_step = 1'b1;
                    if (status.data_fin)
                        state_next = ST_DONE;
                end
                ST_DONE: ;
                default: ;
            endcase
        end
        else if (state_reg == ST_DIV && status.div_done)
        begin
            cmd.frames_load = 1'b1;
            state_next      = status.quot_zero ? ST_DONE : ST_DATA;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_HEADER;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

### src/wav_pcm_stream_parser.sv
// WAV PCM stream parser.
// Slave stream: one file byte per beat on s_tdata; s_tuser marks byte 0 of
// a new file and restarts the header parse from that byte. The first 44
// bytes are the canonical RIFF header; channel count, block align, bits per
// sample and data size are kept from it.
// Master stream: one beat per frame carrying the first channel's sample in
// Q1.15 (16-bit samples pass, 8-bit samples scaled by 258 around 128, other
// widths give 0). m_tlast flags the final frame; m_tuser flags the error beat
// sent when block align is zero, after which no samples follow.
// Throughput: one byte per cycle when not stalled. Besides the receiver stall
// below, s_tready drops after the header while the frame count divide
// (data size / block align) runs, one quotient bit per cycle.
// Latency: a sample beat appears on the master side the cycle after the byte
// that completes it is taken.
// Reset leaves the parser waiting for header byte 0 with no beat pending.
// When the receiver stalls, the held beat stays in the output register and
// s_tready drops until that beat is taken; no byte is taken meanwhile.
// After the final frame, bytes are taken and dropped until the next start.
`default_nettype none

module wav_pcm_stream_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] start_of_stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] sample_value
    output logic             m_tlast,   // last_sample
    output logic             m_tuser    // [0] error_code
);
    import wpp_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Controller: parse phase, handshake, commands to the datapath
    wpp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_start (s_tuser),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: header fields, frame counters, sample assembly, divider,
    // output register
    wpp_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .data_byte (s_tdata),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_value (m_tdata),
        .out_last  (m_tlast),
        .out_err   (m_tuser)
    );

endmodule

`default_nettype wire

### src/wpp_checker.sv
`default_nettype none

module wpp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic        m_tuser
);

    // A held beat keeps its place
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    // The error beat carries no sample and no frame end
    a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata == 16'd0) && !m_tlast)
        else $error("error beat with sample content");

    // No byte is taken while a result waits on a stalled receiver
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken over a stalled result");

    // A new beat only follows an accepted byte
    a_beat_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result without an input byte");

endmodule

bind wav_pcm_stream_parser wpp_checker u_wpp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

### tb/sv/wav_pcm_stream_parser_check.sv
`timescale 1ns / 100ps

module wav_pcm_stream_parser_check
    import wpp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] start_of_stream
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,    // [15:0] sample_value
    input  logic        m_tlast,    // last_sample
    input  logic        m_tuser,    // [0] error_code
    output int          fault_count,
    output int          outstanding
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_DATA,
        PH_DONE
    } parse_phase_t;

    typedef struct packed {
        logic [15:0] value;
        logic        last;
        logic        err;
    } pcm_beat_t;

    pcm_beat_t    pending_samples[$];

    parse_phase_t phase = PH_HEADER;
    logic [5:0]   hdr_pos = '0;
    logic [15:0]  n_chan = '0;
    logic [15:0]  align = '0;
    logic [15:0]  bits_per = '0;
    logic [31:0]  data_bytes = '0;
    logic [31:0]  frames_todo = '0;
    int unsigned  sub_byte = 0;
    int unsigned  chan_now = 0;
    logic [31:0]  accum = '0;

    initial fault_count = 0;
    initial outstanding = 0;

    task automatic restart_parse();
        phase       = PH_HEADER;
        hdr_pos     = '0;
        n_chan      = '0;
        align       = '0;
        bits_per    = '0;
        data_bytes  = '0;
        frames_todo = '0;
        sub_byte    = 0;
        chan_now    = 0;
        accum       = '0;
    endtask

    // Append one expected beat at the tail of the queue
    task automatic queue_beat(input logic [15:0] value, input logic last, input logic err);
        pcm_beat_t beat;
        beat.value      = value;
        beat.last       = last;
        beat.err        = err;
        pending_samples = {pending_samples, beat};
    endtask

    function automatic logic [15:0] to_q15(logic [31:0] raw, logic [15:0] width);
        int v;
        if (width == BITS_8)
        begin
            v = (int'(raw[7:0]) - 128) * 258;
            if (v < -32768)
                v = -32768;
        end
        else if (width == BITS_16)
            v = int'(raw[15:0]);
        else
            v = 0;
        return v[15:0];
    endfunction

    task automatic close_frame();
        chan_now    = 0;
        accum       = '0;
        frames_todo = frames_todo - 1;
        if (frames_todo == 0)
            phase = PH_DONE;
    endtask

    // Advance the parser by one accepted byte; queue any sample it yields.
    task automatic parse_byte(input logic [7:0] b, input logic sos);
        int unsigned width_bytes;
        int unsigned chans;
        logic        last;
        logic        emit;
        logic [15:0] value;
        if (sos)
            restart_parse();
        width_bytes = bits_per >> 3;
        chans       = (n_chan == 0) ? 1 : n_chan;
        if (phase == PH_HEADER)
        begin
            case (hdr_pos)
                POS_CHAN_LO:  n_chan[7:0]       = b;
                POS_CHAN_HI:  n_chan[15:8]      = b;
                POS_ALIGN_LO: align[7:0]        = b;
                POS_ALIGN_HI: align[15:8]       = b;
                POS_BITS_LO:  bits_per[7:0]     = b;
                POS_BITS_HI:  bits_per[15:8]    = b;
                POS_SIZE_B0:  data_bytes[7:0]   = b;
                POS_SIZE_B1:  data_bytes[15:8]  = b;
                POS_SIZE_B2:  data_bytes[23:16] = b;
                POS_SIZE_B3:  data_bytes[31:24] = b;
                default: ;
            endcase
            if (hdr_pos != POS_HDR_LAST)
                hdr_pos = hdr_pos + 6'd1;
            else
            begin
                hdr_pos  = '0;
                sub_byte = 0;
                chan_now = 0;
                accum    = '0;
                if (align == 0)
                begin
                    // zero block align: one error beat, then nothing
                    phase = PH_DONE;
                    queue_beat('0, 1'b0, 1'b1);
                end
                else
                begin
                    frames_todo = data_bytes / {16'd0, align};
                    phase = (frames_todo != 0) ? PH_DATA : PH_DONE;
                end
            end
        end
        else if (phase == PH_DATA)
        begin
            if (width_bytes == 0)
            begin
                // sub-byte width: every byte is a whole frame worth zero
                last = (frames_todo == 1);
                close_frame();
                queue_beat('0, last, 1'b0);
            end
            else
            begin
                if (chan_now == 0 && sub_byte < 4)
                    accum = accum | (32'(b) << (8 * sub_byte));
                sub_byte++;
                if (sub_byte >= width_bytes)
                begin
                    sub_byte = 0;
                    emit  = (chan_now == 0);
                    value = emit ? to_q15(accum, bits_per) : '0;
                    last  = (frames_todo == 1);
                    chan_now++;
                    if (chan_now >= chans)
                        close_frame();
                    if (emit)
                        queue_beat(value, last, 1'b0);
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t ns mismatch: %s", $time, what);
        fault_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pcm_beat_t want;
        if (!rst_n)
        begin
            restart_parse();
            pending_samples.delete();
            outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_samples.size() == 0)
                    report_mismatch($sformatf("unexpected beat data=%h last=%b user=%b",
                                              m_tdata, m_tlast, m_tuser));
                else
                begin
                    want = pending_samples.pop_front();
                    if (m_tdata !== want.value)
                        report_mismatch($sformatf("sample %h, want %h", m_tdata, want.value));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("last %b, want %b", m_tlast, want.last));
                    if (m_tuser !== want.err)
                        report_mismatch($sformatf("error %b, want %b", m_tuser, want.err));
                end
            end
            if (s_tvalid && s_tready)
                parse_byte(s_tdata, s_tuser);
            outstanding <= pending_samples.size();
        end
    end

endmodule

### tb/sv/wav_pcm_stream_parser_test.sv
`timescale 1ns / 100ps

module wav_pcm_stream_parser_test;
    import wpp_pkg::*;

    // Bytes of random stimulus to send, trailing junk not counted
    localparam int RANDOM_BYTES = 800;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;      // [7:0] data_byte
    logic        s_tuser = 1'b0;    // [0] start_of_stream
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [15:0] sample_value
    logic        m_tlast;           // last_sample
    logic        m_tuser;           // [0] error_code

    int          fault_count;
    int          outstanding;

    // Hold both sides free of idle cycles while set
    logic        calm = 1'b0;

    // Data chunk of the next file, sent after its header
    logic [7:0]  payload[$];

    always #5 clk = ~clk;

    wav_pcm_stream_parser uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    wav_pcm_stream_parser_check sample_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .fault_count (fault_count),
        .outstanding (outstanding)
    );

    // Receiver: stall at random, except during the calm stretch
    always @(posedge clk)
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 35);

    // Offer one byte, idling first at random; return at the edge that takes it.
    // The next call drives in the same time step, so tvalid never drops
    // between back-to-back beats.
    task automatic push_byte(input logic [7:0] b, input logic sos);
        while (!calm && $urandom_range(99) < 35)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= sos;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Hold the sender until every expected sample has been taken
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic fill_random(input int n);
        payload.delete();
        for (int i = 0; i < n; i++)
            payload = {payload, 8'($urandom_range(255))};
    endtask

    // Bytes past the data chunk; the parser drops them in its done state
    task automatic send_junk(input int n);
        for (int i = 0; i < n; i++)
            push_byte(8'($urandom_range(255)), 1'b0);
    endtask

    // Send one file: header with the given fields (other bytes random), then payload
    task automatic send_wav(input logic marked, input logic [15:0] chans,
                            input logic [15:0] blk_align, input logic [15:0] bits,
                            input logic [31:0] data_len);
        logic [7:0] hdr[HEADER_BYTES];
        for (int i = 0; i < HEADER_BYTES; i++)
            hdr[i] = 8'($urandom_range(255));
        hdr[POS_CHAN_LO]  = chans[7:0];
        hdr[POS_CHAN_HI]  = chans[15:8];
        hdr[POS_ALIGN_LO] = blk_align[7:0];
        hdr[POS_ALIGN_HI] = blk_align[15:8];
        hdr[POS_BITS_LO]  = bits[7:0];
        hdr[POS_BITS_HI]  = bits[15:8];
        hdr[POS_SIZE_B0]  = data_len[7:0];
        hdr[POS_SIZE_B1]  = data_len[15:8];
        hdr[POS_SIZE_B2]  = data_len[23:16];
        hdr[POS_SIZE_B3]  = data_len[31:24];
        for (int i = 0; i < HEADER_BYTES; i++)
            push_byte(hdr[i], marked && i == 0);
        foreach (payload[i])
            push_byte(payload[i], 1'b0);
    endtask

    initial
    begin
        int          counted;
        int          pick;
        int          n;
        logic [15:0] chans;
        logic [15:0] blk_align;
        logic [15:0] bits;
        logic [31:0] data_len;
        logic [31:0] frames;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed files ---

        // 16-bit mono without a start mark after reset: both rails, zero, -1
        payload = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'hFF, 8'hFF};
        send_wav(1'b0, 16'd1, 16'd2, BITS_16, 32'd8);
        send_junk(3);

        // 8-bit mono: saturating low end, near-min, midscale, top
        payload = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};
        send_wav(1'b1, 16'd1, 16'd1, BITS_8, 32'd5);

        // 16-bit stereo: drop the second channel of each frame
        payload = '{8'h34, 8'h12, 8'hAA, 8'hBB, 8'hCD, 8'hAB, 8'h11, 8'h22};
        send_wav(1'b1, 16'd2, 16'd4, BITS_16, 32'd8);

        // zero block align: one error beat, rest of the stream dropped
        payload.delete();
        send_wav(1'b1, 16'd1, 16'd0, BITS_16, 32'd100);
        send_junk(4);

        // data size under one frame: no samples at all
        send_wav(1'b1, 16'd2, 16'd4, BITS_16, 32'd3);
        send_junk(4);

        // channel count zero reads as mono
        payload = '{8'h10, 8'hF0, 8'h80};
        send_wav(1'b1, 16'd0, 16'd1, BITS_8, 32'd3);

        // width under 8 bits: each data byte is a frame worth zero
        payload = '{8'h5A, 8'hA5, 8'h3C};
        send_wav(1'b1, 16'd1, 16'd1, 16'd4, 32'd3);

        // 48-bit stereo: wide samples consumed whole, value zero
        fill_random(24);
        send_wav(1'b1, 16'd2, 16'd12, 16'd48, 32'd24);

        // 24-bit mono with one stray byte past the last frame
        fill_random(7);
        send_wav(1'b1, 16'd1, 16'd3, 16'd24, 32'd7);

        // restart in the middle of a header
        payload.delete();
        for (int i = 0; i < 20; i++)
            push_byte(8'($urandom_range(255)), i == 0);

        // huge frame counts, cut short by the next start mark
        fill_random(12);
        send_wav(1'b1, 16'd1, 16'd1, BITS_8, 32'hFFFF_FFFF);
        fill_random(20);
        send_wav(1'b1, 16'hFFFF, 16'hFFFF, BITS_8, 32'hFFFF_FFFF);
        fill_random(6);
        send_wav(1'b1, 16'd1, 16'd2, 16'hFFFF, 32'h0000_1000);

        drain();

        // --- random files ---
        counted = 0;
        while (counted < RANDOM_BYTES)
        begin
            calm = (counted >= 250 && counted < 600);
            pick = $urandom_range(99);
            if (pick < 72)
            begin
                // well-formed file with random samples
                chans = 16'($urandom_range(3));
                case ($urandom_range(9))
                    0, 1, 2, 3: bits = BITS_16;
                    4, 5, 6:    bits = BITS_8;
                    7:          bits = 16'($urandom_range(7));
                    8:          bits = 16'd24;
                    default:    bits = 16'($urandom_range(64));
                endcase
                blk_align = ((chans == 0) ? 16'd1 : chans) * (bits >> 3);
                if (blk_align == 0 || $urandom_range(9) == 0)
                    blk_align = 16'($urandom_range(1, 9));
                frames   = $urandom_range(1, 10);
                data_len = frames * blk_align + $urandom_range(0, blk_align - 1);
                fill_random(data_len);
                send_wav(1'b1, chans, blk_align, bits, data_len);
                counted += HEADER_BYTES + data_len;
                if ($urandom_range(3) == 0)
                    send_junk($urandom_range(1, 6));
            end
            else if (pick < 82)
            begin
                // header that yields no samples
                blk_align = $urandom_range(1) ? 16'd0 : 16'($urandom_range(1, 16));
                data_len  = (blk_align == 0) ? $urandom : $urandom_range(0, blk_align - 1);
                payload.delete();
                send_wav(1'b1, 16'($urandom), blk_align, 16'($urandom), data_len);
                counted += HEADER_BYTES;
                send_junk($urandom_range(0, 4));
            end
            else if (pick < 94)
            begin
                // random header fields, data cut short
                n = $urandom_range(0, 30);
                fill_random(n);
                send_wav(1'b1, 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
                counted += HEADER_BYTES + n;
            end
            else
            begin
                // noise, with an occasional stray start mark
                n = $urandom_range(1, 20);
                for (int i = 0; i < n; i++)
                    push_byte(8'($urandom_range(255)), $urandom_range(15) == 0);
                counted += n;
            end
            if ($urandom_range(49) == 0)
                drain();
        end
        calm = 1'b0;

        // drain, then give stray beats time to show up
        drain();
        repeat (64) @(posedge clk);
        if (fault_count == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
src/wpp_pkg.sv
src/wpp_div.sv
src/wpp_dpath.sv
src/wpp_ctrl.sv
src/wav_pcm_stream_parser.sv
src/wpp_checker.sv
tb/sv/wav_pcm_stream_parser_check.sv
tb/sv/wav_pcm_stream_parser_test.sv
